// File: src/zap_pkg.sv
// ----------------------------------------------------------------------------
// zap_pkg: shared types and constants
// Status codes, controller/datapath handshake structs and the delta tables
// of the ADPCM audio decoder.
// ----------------------------------------------------------------------------
package zap_pkg;

	localparam int LEN_REG_BITS = 16;
	localparam int APB_ADDR_BITS = 3;
	localparam logic REG_OUTPUT_LENGTH = 1'b0;
	localparam logic [7:0] SAMPLE_INIT = 8'h80;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DONE = 2'd1,
		ST_ERR  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MODE_TWO   = 2'd0,
		MODE_FOUR  = 2'd1,
		MODE_RAW   = 2'd2,
		MODE_RPT   = 2'd3
	} mode_t;

	typedef struct packed {
		logic accept;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic has_results;
		logic step_last;
	} sts_t;

	function automatic logic signed [4:0] tab_two(input logic [1:0] code);
		logic signed [4:0] d;
		case (code)
			2'd0: d = -5'sd2;
			2'd1: d = -5'sd1;
			2'd2: d = 5'sd0;
			2'd3: d = 5'sd1;
			default: d = 5'sd0;
		endcase
		return d;
	endfunction

	function automatic logic signed [4:0] tab_four(input logic [3:0] code);
		logic signed [4:0] d;
		case (code)
			4'd0: d = -5'sd9;
			4'd1: d = -5'sd8;
			4'd2: d = -5'sd6;
			4'd3: d = -5'sd5;
			4'd4: d = -5'sd4;
			4'd5: d = -5'sd3;
			4'd6: d = -5'sd2;
			4'd7: d = -5'sd1;
			4'd8: d = 5'sd0;
			4'd9: d = 5'sd1;
			4'd10: d = 5'sd2;
			4'd11: d = 5'sd3;
			4'd12: d = 5'sd4;
			4'd13: d = 5'sd5;
			4'd14: d = 5'sd6;
			4'd15: d = 5'sd8;
			default: d = 5'sd0;
		endcase
		return d;
	endfunction

endpackage

// File: src/zap_stream_if.sv
// ----------------------------------------------------------------------------
// zap stream interfaces
// Valid/ready channels for compressed source bytes and decoded samples.
// ----------------------------------------------------------------------------
interface zap_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_stream;
	logic       end_of_source;

	modport source (output valid, data_byte, start_of_stream, end_of_source, input ready);
	modport sink (input valid, data_byte, start_of_stream, end_of_source, output ready);
endinterface

interface zap_sample_if;
	logic       valid;
	logic       ready;
	logic [7:0] sample_out;
	logic       last_of_run;
	logic [1:0] status;

	modport source (output valid, sample_out, last_of_run, status, input ready);
	modport sink (input valid, sample_out, last_of_run, status, output ready);
endinterface

// File: src/zap_adpcm_audio_decoder.sv
// ----------------------------------------------------------------------------
// zap_adpcm_audio_decoder: ADPCM audio decoder, top level
// Compressed source bytes come in on byte_ch, one per transfer, and unsigned
// 8-bit samples leave on sample_ch, up to 64 per source byte. Each sample
// carries last_of_run on the final result of its byte and a status code
// (valid, stream complete, source exhausted).
// The output_length register (APB, byte address 0) sets how many samples a
// stream yields; write it only while the decoder is idle.
// A byte is taken while the decoder is idle; its results are then formed one
// per cycle into the output register, and the byte holds the input until its
// last result is formed (a header byte with no result does not). The single
// shared sample adder and the one-deep output register set this. Results are
// registered, showing in the cycle after they are formed. While sample_ch is
// stalled the decoder holds its current result and stops stepping; a new byte
// is still taken once the previous byte has formed all its results.
// Reset puts the running sample at 128, clears all counters and sets
// output_length to 1; start_of_stream restarts a stream without touching
// output_length.
// ----------------------------------------------------------------------------
module zap_adpcm_audio_decoder import zap_pkg::*; #(
	parameter int LENGTH_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	zap_byte_if.sink                 byte_ch,
	zap_sample_if.source             sample_ch,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	logic [LEN_REG_BITS-1:0] len_q;
	logic                    reg_hit;
	cmd_t                    cmd;
	sts_t                    sts;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_OUTPUT_LENGTH);
	assign prdata  = reg_hit ? 32'(len_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_REG_BITS'(1);
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			len_q <= pwdata[LEN_REG_BITS-1:0];
		end
	end

	zap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (byte_ch.valid),
		.in_ready  (byte_ch.ready),
		.out_valid (sample_ch.valid),
		.out_ready (sample_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	zap_dp #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.data_byte       (byte_ch.data_byte),
		.start_of_stream (byte_ch.start_of_stream),
		.end_of_source   (byte_ch.end_of_source),
		.output_length   (len_q),
		.sample_out      (sample_ch.sample_out),
		.last_of_run     (sample_ch.last_of_run),
		.status          (sample_ch.status)
	);

endmodule

// File: src/zap_ctrl.sv
// ----------------------------------------------------------------------------
// zap_ctrl: decoder controller
// Takes one source byte at a time and sequences one result per step into
// the output register, holding off the source until the byte is done.
// ----------------------------------------------------------------------------
module zap_ctrl import zap_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	typedef enum logic {
		IDLE,
		EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready   = (state_q == IDLE);
	assign out_free   = !out_valid_q || out_ready;
	assign cmd.accept = in_valid && in_ready;
	assign cmd.step   = (state_q == EMIT) && out_free;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (cmd.accept && sts.has_results) begin
						state_q <= EMIT;
					end
				end
				EMIT: begin
					if (cmd.step && sts.step_last) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// File: src/zap_dp.sv
// ----------------------------------------------------------------------------
// zap_dp: decoder datapath
// Holds the stream state, decodes header and payload bytes, and forms one
// clamped sample per step into the output register.
// ----------------------------------------------------------------------------
module zap_dp import zap_pkg::*; #(
	parameter int LENGTH_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	input  logic [7:0]              data_byte,
	input  logic                    start_of_stream,
	input  logic                    end_of_source,
	input  logic [LEN_REG_BITS-1:0] output_length,
	output logic [7:0]              sample_out,
	output logic                    last_of_run,
	output logic [1:0]              status
);

	localparam int EXT_BITS = (LENGTH_BITS > LEN_REG_BITS) ? LENGTH_BITS : LEN_REG_BITS;

	typedef enum logic [2:0] {
		K_TWO,
		K_FOUR,
		K_RAW,
		K_RPT,
		K_DELTA,
		K_ERR
	} kind_t;

	// stream state
	logic [7:0]             rs_q;
	mode_t                  mode_q;
	logic                   pay_q;
	logic [5:0]             rem_q;
	logic [LENGTH_BITS-1:0] sw_q;
	logic                   fin_q;

	// byte being worked
	logic [7:0] byte_q;
	logic       eos_q;
	kind_t      kind_q;
	logic [5:0] idx_q;
	logic [5:0] last_idx_q;

	logic [7:0]       sample_q;
	logic             last_q;
	status_t          status_q;

	logic [EXT_BITS-1:0]    len_ext;
	logic [LENGTH_BITS-1:0] eff_len;

	logic [7:0]             rs_e;
	logic [LENGTH_BITS-1:0] sw_e;
	logic                   pay_e;
	logic                   fin_e;
	logic                   skip;
	mode_t                  code;
	logic [5:0]             cnt;
	logic                   is_delta;

	logic signed [4:0] delta;
	logic signed [9:0] sum;
	logic [7:0]        new_s;
	logic [LENGTH_BITS-1:0] sw_n;
	logic              complete;
	logic              last;
	status_t           st;

	assign len_ext = EXT_BITS'(output_length);
	assign eff_len = len_ext[LENGTH_BITS-1:0];

	// accept side
	assign rs_e     = start_of_stream ? SAMPLE_INIT : rs_q;
	assign sw_e     = start_of_stream ? '0 : sw_q;
	assign pay_e    = start_of_stream ? 1'b0 : pay_q;
	assign fin_e    = start_of_stream ? 1'b0 : fin_q;
	assign skip     = fin_e || (sw_e >= eff_len);
	assign code     = mode_t'(data_byte[7:6]);
	assign cnt      = data_byte[5:0];
	assign is_delta = (code == MODE_RAW) && cnt[5];

	assign sts.has_results = !skip && (pay_e || code == MODE_RPT || is_delta || end_of_source);

	// step side
	always_comb begin
		case (kind_q)
			K_TWO: begin
				case (idx_q[1:0])
					2'd0: delta = tab_two(byte_q[1:0]);
					2'd1: delta = tab_two(byte_q[3:2]);
					2'd2: delta = tab_two(byte_q[5:4]);
					default: delta = tab_two(byte_q[7:6]);
				endcase
			end
			K_FOUR: delta = idx_q[0] ? tab_four(byte_q[7:4]) : tab_four(byte_q[3:0]);
			K_DELTA: delta = $signed(byte_q[4:0]);
			default: delta = 5'sd0;
		endcase
	end

	assign sum = $signed({2'b00, rs_q}) + $signed({{5{delta[4]}}, delta});

	always_comb begin
		if (kind_q == K_RAW) begin
			new_s = byte_q;
		end else if (sum < 10'sd0) begin
			new_s = 8'd0;
		end else if (sum > 10'sd255) begin
			new_s = 8'd255;
		end else begin
			new_s = sum[7:0];
		end
	end

	assign sw_n     = sw_q + LENGTH_BITS'(1);
	assign complete = (kind_q != K_ERR) && (sw_n >= eff_len);
	assign last     = complete || (idx_q == last_idx_q);

	always_comb begin
		if (complete) begin
			st = ST_DONE;
		end else if (last && eos_q) begin
			st = ST_ERR;
		end else begin
			st = ST_OK;
		end
	end

	assign sts.step_last = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q       <= SAMPLE_INIT;
			mode_q     <= MODE_TWO;
			pay_q      <= 1'b0;
			rem_q      <= '0;
			sw_q       <= '0;
			fin_q      <= 1'b0;
			eos_q      <= 1'b0;
			kind_q     <= K_TWO;
			idx_q      <= '0;
			last_idx_q <= '0;
		end else if (cmd.accept) begin
			rs_q   <= rs_e;
			sw_q   <= sw_e;
			fin_q  <= skip ? 1'b1 : fin_e;
			pay_q  <= pay_e;
			eos_q  <= end_of_source;
			idx_q  <= '0;
			if (start_of_stream) begin
				mode_q <= MODE_TWO;
				rem_q  <= '0;
			end
			if (!skip) begin
				if (pay_e) begin
					case (mode_q)
						MODE_TWO: begin
							kind_q     <= K_TWO;
							last_idx_q <= 6'd3;
						end
						MODE_FOUR: begin
							kind_q     <= K_FOUR;
							last_idx_q <= 6'd1;
						end
						default: begin
							kind_q     <= K_RAW;
							last_idx_q <= 6'd0;
						end
					endcase
					if (rem_q == 6'd0 || start_of_stream) begin
						pay_q <= 1'b0;
					end else begin
						rem_q <= rem_q - 6'd1;
					end
				end else if (code == MODE_RPT) begin
					kind_q     <= K_RPT;
					last_idx_q <= cnt;
				end else if (is_delta) begin
					kind_q     <= K_DELTA;
					last_idx_q <= 6'd0;
				end else begin
					mode_q     <= code;
					rem_q      <= cnt;
					pay_q      <= 1'b1;
					kind_q     <= K_ERR;
					last_idx_q <= 6'd0;
				end
			end
		end else if (cmd.step) begin
			idx_q <= idx_q + 6'd1;
			if (kind_q != K_ERR) begin
				rs_q <= new_s;
				sw_q <= sw_n;
			end
			if (complete || (last && eos_q)) begin
				fin_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= data_byte;
		end
		if (cmd.step) begin
			sample_q <= (kind_q == K_ERR) ? rs_q : new_s;
			last_q   <= last;
			status_q <= (kind_q == K_ERR) ? ST_ERR : st;
		end
	end

	assign sample_out  = sample_q;
	assign last_of_run = last_q;
	assign status      = status_q;

endmodule

// File: src/zap_checker.sv
// ----------------------------------------------------------------------------
// zap_checker: port-level checks for the ADPCM audio decoder
// Watches the byte and sample channels and flags sequencing slips.
// ----------------------------------------------------------------------------
module zap_checker import zap_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] sample_out,
	input logic       last_of_run,
	input logic [1:0] status
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out)
		&& $stable(last_of_run) && $stable(status))
		else $error("result changed while stalled");

	// completion and error close the run of a byte
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_DONE || status == ST_ERR) |-> last_of_run)
		else $error("stream end without last_of_run");

	// a byte's results come back to back when the sink keeps up
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("gap inside a run");

	// no new byte while a run is still open
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |-> !in_ready)
		else $error("byte taken during a run");

endmodule

bind zap_adpcm_audio_decoder zap_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (byte_ch.ready),
	.out_valid   (sample_ch.valid),
	.out_ready   (sample_ch.ready),
	.sample_out  (sample_ch.sample_out),
	.last_of_run (sample_ch.last_of_run),
	.status      (sample_ch.status)
);
